@@ src/page_table_walk_and_map_top_macros.svh @@
// Assertion macros for the page-table walk and map block.
// Used by the top level only; no other dependencies.
`ifndef PAGE_TABLE_WALK_AND_MAP_TOP_MACROS_SVH
`define PAGE_TABLE_WALK_AND_MAP_TOP_MACROS_SVH

// Property that must hold at every edge outside reset.
`define PTW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked at the next edge.
`define PTW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ptwm_pkg.sv @@
// Shared types and constants for the page-table walk and map block.
// No dependencies.
`timescale 1ns / 1ps
package ptwm_pkg;
   localparam int TABLE_FRAMES_DEF = 16;
   localparam int ENTRY_IDX_W = 9;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_XLATE = 2'd2;
   localparam logic [1:0] CMD_MAP   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNMAPPED = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   // result value source
   localparam logic [1:0] VAL_ZERO  = 2'd0;
   localparam logic [1:0] VAL_WORD  = 2'd1;
   localparam logic [1:0] VAL_MISS  = 2'd2;
   localparam logic [1:0] VAL_XLATE = 2'd3;

   localparam logic CSR_ROOT = 1'b0;
   localparam logic CSR_FREE = 1'b1;

   localparam logic [63:0] MISS_VALUE = 64'hDEAD;
   localparam logic [63:0] LINK_FLAGS = 64'd7;
   localparam logic [63:0] PAGE_BYTES = 64'd4096;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_ISSUE, S_RD_WAIT, S_WALK_RD, S_WALK_CHK,
      S_ZERO, S_LINK, S_LEAF, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // capture request
      logic       clr_step;   // write zero at sweep address
      logic       mem_wr;     // plain word write
      logic       rd_req;     // read word at request address
      logic       walk_rd;    // read entry at current level
      logic       zero_step;  // write zero in new frame
      logic       link;       // write link entry, descend
      logic       descend;    // take existing entry, descend
      logic       leaf_wr;    // write leaf, advance index
      logic       carry_up;   // index overflow: go up a level
      logic       set_lvl0;   // restart walk from root
      logic       xl_next;    // translate: descend
      logic       fin;        // latch result
      logic [1:0] fin_status;
      logic [1:0] fin_val;    // VAL_ZERO, VAL_WORD, VAL_MISS, VAL_XLATE
      logic       csr_root;
      logic       csr_free;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       clr_done;
      logic       addr_oor;
      logic [1:0] cmd;
      logic       cnt_zero;
      logic       root_oor;
      logic       entry_zero;
      logic       entry_oor;
      logic       alloc_oor;
      logic       zero_done;
      logic [1:0] lvl;
      logic       idx_over;   // index at current level passed the top
      logic       last_page;
   } stat_type;
endpackage

@@ src/ptwm_dp.sv @@
// Datapath: table store, walk registers, allocator and result register.
// Depends on ptwm_pkg.
`timescale 1ns / 1ps
module ptwm_dp #(
   parameter int TABLE_FRAMES = ptwm_pkg::TABLE_FRAMES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ptwm_pkg::cmd_type ctl,
   output ptwm_pkg::stat_type st,
   input  logic [1:0]        req_cmd,
   input  logic [63:0]       req_address,
   input  logic [63:0]       req_data,
   input  logic [20:0]       req_page_count,
   input  logic [11:0]       req_entry_flags,
   input  logic [4:0]        csr_wdata,
   output logic [63:0]       value,
   output logic [1:0]        status
);
   import ptwm_pkg::*;
   localparam int FW = (TABLE_FRAMES > 2) ? $clog2(TABLE_FRAMES) : 1;
   localparam int AW = FW + ENTRY_IDX_W;
   localparam int DEPTH = TABLE_FRAMES * 512;
   // root register holds the full 4-bit setting, allocator the full 5-bit one
   localparam int RW = (FW > 4) ? FW : 4;
   localparam int NW = (FW + 1 > 5) ? FW + 1 : 5;

   logic [63:0] mem [DEPTH];
   logic [63:0] rdata_ff;

   logic [1:0]  cmd_ff;
   logic [63:0] va_ff, data_ff;
   logic [20:0] cnt_ff;
   logic [11:0] flg_ff;
   logic [9:0]  idx_ff [4];
   logic [FW-1:0] tab_ff [4];
   logic [1:0]  lvl_ff;
   logic [RW-1:0] root_ff;
   logic [NW-1:0] next_ff;
   logic [AW:0]   sweep_ff;
   logic [63:0] value_ff;
   logic [1:0]  status_ff;

   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr, ent_addr;
   logic [63:0] wr_data;
   logic        rd_en;
   logic [63:0] nv;

   assign ent_addr = {tab_ff[lvl_ff], idx_ff[lvl_ff][ENTRY_IDX_W-1:0]};

   // pick the store access for this cycle
   always_comb begin
      wr_en = 1'b0; wr_addr = ent_addr; wr_data = '0;
      rd_en = ctl.rd_req | ctl.walk_rd;
      rd_addr = ctl.rd_req ? va_ff[AW+2:3] : ent_addr;
      if (ctl.clr_step) begin
         wr_en = 1'b1; wr_addr = sweep_ff[AW-1:0];
      end else if (ctl.mem_wr) begin
         wr_en = 1'b1; wr_addr = va_ff[AW+2:3]; wr_data = data_ff;
      end else if (ctl.zero_step) begin
         wr_en = 1'b1; wr_addr = {next_ff[FW-1:0], sweep_ff[ENTRY_IDX_W-1:0]};
      end else if (ctl.link) begin
         wr_en = 1'b1;
         wr_data = ({{(64-FW-12){1'b0}}, next_ff[FW-1:0], 12'd0})
                   | {52'd0, flg_ff} | LINK_FLAGS;
      end else if (ctl.leaf_wr) begin
         wr_en = 1'b1; wr_data = data_ff | {52'd0, flg_ff};
      end
   end

   // store port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // status toward the controller
   always_comb begin
      st.clr_done   = (sweep_ff == (AW+1)'(DEPTH - 1)) || (sweep_ff >= (AW+1)'(DEPTH));
      st.addr_oor   = (va_ff[63:3] >= 61'(DEPTH));
      st.cmd        = cmd_ff;
      st.cnt_zero   = (cnt_ff == '0);
      st.root_oor   = ({1'b0, root_ff} >= (RW+1)'(TABLE_FRAMES));
      st.entry_zero = (rdata_ff == '0);
      st.entry_oor  = (rdata_ff[63:12] >= 52'(TABLE_FRAMES));
      st.alloc_oor  = (next_ff >= NW'(TABLE_FRAMES));
      st.zero_done  = (sweep_ff[ENTRY_IDX_W-1:0] == '1);
      st.lvl        = lvl_ff;
      st.idx_over   = idx_ff[lvl_ff][ENTRY_IDX_W];
      st.last_page  = (cnt_ff == 21'd1);
   end

   // result value
   always_comb begin
      case (ctl.fin_val)
         VAL_WORD:  nv = rdata_ff;
         VAL_MISS:  nv = MISS_VALUE;
         VAL_XLATE: nv = {rdata_ff[63:12], va_ff[11:0]};
         default:   nv = '0;
      endcase
   end

   // walk registers and allocator
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         root_ff  <= '0;
         next_ff  <= NW'(1);
      end else begin
         if (ctl.clr_step || ctl.zero_step) sweep_ff <= sweep_ff + 1'b1;
         if (ctl.link) sweep_ff <= '0;
         if (ctl.csr_root) root_ff <= RW'(csr_wdata[3:0]);
         if (ctl.csr_free) next_ff <= NW'(csr_wdata);
         if (ctl.link) next_ff <= next_ff + 1'b1;
         if (ctl.load) sweep_ff <= '0;
      end
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         va_ff   <= req_address;
         data_ff <= req_data;
         cnt_ff  <= req_page_count;
         flg_ff  <= req_entry_flags;
         idx_ff[0] <= {1'b0, req_address[47:39]};
         idx_ff[1] <= {1'b0, req_address[38:30]};
         idx_ff[2] <= {1'b0, req_address[29:21]};
         idx_ff[3] <= {1'b0, req_address[20:12]};
      end
      if (ctl.set_lvl0) begin
         lvl_ff    <= 2'd0;
         tab_ff[0] <= root_ff[FW-1:0];
      end
      if (ctl.xl_next || ctl.descend) begin
         tab_ff[lvl_ff + 2'd1] <= rdata_ff[FW+11:12];
         lvl_ff <= lvl_ff + 2'd1;
      end
      if (ctl.link) begin
         tab_ff[lvl_ff + 2'd1] <= next_ff[FW-1:0];
         lvl_ff <= lvl_ff + 2'd1;
      end
      if (ctl.leaf_wr) begin
         idx_ff[3] <= idx_ff[3] + 10'd1;
         data_ff   <= data_ff + PAGE_BYTES;
         cnt_ff    <= cnt_ff - 21'd1;
      end
      if (ctl.carry_up) begin
         idx_ff[lvl_ff] <= '0;
         idx_ff[lvl_ff - 2'd1] <= idx_ff[lvl_ff - 2'd1] + 10'd1;
         lvl_ff <= lvl_ff - 2'd1;
      end
      if (ctl.fin) begin
         value_ff  <= nv;
         status_ff <= ctl.fin_status;
      end
   end

   assign value  = value_ff;
   assign status = status_ff;
endmodule

@@ src/ptwm_ctrl.sv @@
// Controller: sequences clearing, word access, translate walk and map run.
// Depends on ptwm_pkg.
`timescale 1ns / 1ps
module ptwm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  ptwm_pkg::stat_type st,
   output ptwm_pkg::cmd_type  ctl,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic               csr_we,
   input  logic               csr_index,
   output logic               busy
);
   import ptwm_pkg::*;
   state_type state_ff, state_in;
   logic rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_ff;
   assign busy = (state_ff != S_IDLE) && (state_ff != S_CLEAR);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl = '0;
      ctl.csr_root = csr_we && (csr_index == CSR_ROOT);
      ctl.csr_free = csr_we && (csr_index == CSR_FREE);
      rsp_in = rsp_ff && !rsp_tready;
      req_tready = (state_ff == S_IDLE) && !rsp_ff;
      case (state_ff)
         S_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (st.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               ctl.load = 1'b1;
               state_in = S_RD_ISSUE;
            end
         end
         S_RD_ISSUE: begin
            ctl.set_lvl0 = 1'b1;
            ctl.fin_status = ST_OK;
            state_in = S_DONE;
            case (st.cmd)
               CMD_WRITE, CMD_READ: begin
                  if (st.addr_oor) begin
                     ctl.fin = 1'b1; ctl.fin_status = ST_RANGE;
                  end else if (st.cmd == CMD_WRITE) begin
                     ctl.mem_wr = 1'b1; ctl.fin = 1'b1;
                  end else begin
                     ctl.rd_req = 1'b1; state_in = S_RD_WAIT;
                  end
               end
               default: begin
                  if (st.cmd == CMD_MAP && st.cnt_zero) begin
                     ctl.fin = 1'b1;
                  end else if (st.root_oor) begin
                     ctl.fin = 1'b1; ctl.fin_status = ST_RANGE;
                  end else begin
                     state_in = S_WALK_RD;
                  end
               end
            endcase
         end
         S_RD_WAIT: begin
            ctl.fin = 1'b1; ctl.fin_val = VAL_WORD; ctl.fin_status = ST_OK;
            state_in = S_DONE;
         end
         S_WALK_RD: begin
            if (st.cmd == CMD_MAP && st.idx_over) begin
               if (st.lvl == 2'd0) begin
                  ctl.fin = 1'b1; ctl.fin_status = ST_NO_SPACE;
                  state_in = S_DONE;
               end else begin
                  ctl.carry_up = 1'b1;
               end
            end else if (st.cmd == CMD_MAP && st.lvl == 2'd3) begin
               state_in = S_LEAF;
            end else begin
               ctl.walk_rd = 1'b1;
               state_in = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            state_in = S_WALK_RD;
            if (st.cmd == CMD_XLATE) begin
               if (st.entry_zero) begin
                  ctl.fin = 1'b1; ctl.fin_val = VAL_MISS; ctl.fin_status = ST_UNMAPPED;
                  state_in = S_DONE;
               end else if (st.lvl == 2'd3) begin
                  ctl.fin = 1'b1; ctl.fin_val = VAL_XLATE; ctl.fin_status = ST_OK;
                  state_in = S_DONE;
               end else if (st.entry_oor) begin
                  ctl.fin = 1'b1; ctl.fin_status = ST_RANGE; state_in = S_DONE;
               end else begin
                  ctl.xl_next = 1'b1;
               end
            end else if (st.entry_zero) begin
               if (st.alloc_oor) begin
                  ctl.fin = 1'b1; ctl.fin_status = ST_RANGE; state_in = S_DONE;
               end else begin
                  state_in = S_ZERO;
               end
            end else if (st.entry_oor) begin
               ctl.fin = 1'b1; ctl.fin_status = ST_RANGE; state_in = S_DONE;
            end else begin
               ctl.descend = 1'b1;
            end
         end
         S_ZERO: begin
            ctl.zero_step = 1'b1;
            if (st.zero_done) state_in = S_LINK;
         end
         S_LINK: begin
            ctl.link = 1'b1;
            state_in = S_WALK_RD;
         end
         S_LEAF: begin
            if (st.idx_over) begin
               ctl.carry_up = 1'b1;
               state_in = S_WALK_RD;
            end else begin
               ctl.leaf_wr = 1'b1;
               if (st.last_page) begin
                  ctl.fin = 1'b1; ctl.fin_status = ST_OK; state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            rsp_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ src/page_table_walk_and_map_top.sv @@
// Page-table walk and map block: top level joining controller and datapath.
// Depends on ptwm_pkg, ptwm_ctrl, ptwm_dp and the macros header.
//
// Use: one request in on req_*, one response out on rsp_*. Requests carry a
// command (write word, read word, translate, map pages). The store holds
// TABLE_FRAMES*512 64-bit words in one single-port memory.
// After reset the controller sweeps the store to zero, one word per cycle,
// with req_tready low; csr writes are taken then. A translate reads one entry
// per level; a map reads each level's entry, zeroes and links a new table
// where that entry is empty, writes a leaf per page and carries the index to
// the level above when it passes the top.
// One request at a time: req_tready rises again once the response register
// is empty. A stalled rsp_tready holds value and status and keeps
// req_tready low. Configuration is written on csr_* while idle.
`timescale 1ns / 1ps
`include "page_table_walk_and_map_top_macros.svh"
module page_table_walk_and_map_top #(
   parameter int TABLE_FRAMES = ptwm_pkg::TABLE_FRAMES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[1:0], address[65:2], data[129:66], page_count[150:130],
   // entry_flags[162:151], zero fill to 168
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // value[63:0], status[65:64], zero fill to 72
   output logic [71:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [4:0]   csr_wdata
);
   import ptwm_pkg::*;
   cmd_type  ctl;
   stat_type st;
   logic [63:0] value;
   logic [1:0]  status;
   logic        busy;

   ptwm_ctrl u_ctrl (
      .clock, .reset, .st, .ctl, .req_tvalid, .req_tready,
      .rsp_tvalid, .rsp_tready, .csr_we, .csr_index, .busy
   );

   ptwm_dp #(.TABLE_FRAMES(TABLE_FRAMES)) u_dp (
      .clock, .reset, .ctl, .st,
      .req_cmd(req_tdata[1:0]), .req_address(req_tdata[65:2]),
      .req_data(req_tdata[129:66]), .req_page_count(req_tdata[150:130]),
      .req_entry_flags(req_tdata[162:151]), .csr_wdata, .value, .status
   );

   assign rsp_tdata = {6'd0, status, value};

   `PTW_ASSERT(a_no_accept_busy, !(req_tready && (busy || rsp_tvalid)), "ready while busy")
   `PTW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response dropped")
   `PTW_ASSERT_NEXT(a_one_write, ctl.mem_wr, !ctl.mem_wr, "double word write")
endmodule
